### hdl/lav_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types, constants and helpers of the look-at view matrix block.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int COORD_W    = 32;
  localparam int NORM_MSB   = 29;
  localparam int SQRT_STEPS = 31;
  localparam int UNIT_PRE   = 7;
  localparam int CROSS_LAT  = 2;
  localparam int XLATE_LAT  = 5;

  localparam logic [1:0] ROW_SIDE = 2'd0;
  localparam logic [1:0] ROW_UP   = 2'd1;
  localparam logic [1:0] ROW_FWD  = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] eye_x;
    logic signed [COORD_W-1:0] eye_y;
    logic signed [COORD_W-1:0] eye_z;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
    logic signed [COORD_W-1:0] up_x;
    logic signed [COORD_W-1:0] up_y;
    logic signed [COORD_W-1:0] up_z;
  } in_req_t;

  typedef struct packed {
    logic [1:0]                row_index;
    logic signed [COORD_W-1:0] col0;
    logic signed [COORD_W-1:0] col1;
    logic signed [COORD_W-1:0] col2;
    logic signed [COORD_W-1:0] col3;
    logic                      degenerate;
    logic                      last_row;
  } out_req_t;

  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [63:0] v);
    logic signed [63:0] cmax;
    logic signed [63:0] cmin;
    cmax = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
    cmin = -(64'sd1 <<< (COORD_W - 1));
    if (v > cmax) begin
      sat_coord = cmax[COORD_W-1:0];
    end else if (v < cmin) begin
      sat_coord = cmin[COORD_W-1:0];
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

endpackage

### hdl/lav_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_delay
// Enabled shift line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module lav_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] pipe_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_r[i] <= pipe_r[i-1];
      end
    end
  end

  assign q = pipe_r[DEPTH-1];

endmodule

### hdl/lav_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_div_lane
// One component lane: pipelined restoring divide of the scaled magnitude by
// the vector length, one quotient bit per stage, then sign.
// ----------------------------------------------------------------------------
module lav_div_lane #(
  parameter int SW        = 30,
  parameter int QW        = 31,
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [SW-1:0]          num,
  input  logic [QW-1:0]          den,
  input  logic                   neg,
  input  logic                   zero,
  output logic [FRAC_BITS+1:0]   quo
);

  localparam int DN = FRAC_BITS + 1;
  localparam int RW = QW + FRAC_BITS + 1;
  localparam int OW = FRAC_BITS + 2;

  logic [RW-1:0] rem_r  [0:DN-1];
  logic [QW-1:0] den_r  [0:DN-1];
  logic [DN-1:0] quo_r  [0:DN];
  logic          neg_r  [0:DN];
  logic          zero_r [0:DN];
  logic [OW-1:0] out_r;

  logic [RW-1:0] rem_nxt [1:DN];
  logic [DN-1:0] quo_nxt [1:DN];
  logic [RW-1:0] dsh     [1:DN];
  logic signed [OW-1:0] qs;

  always_comb begin
    for (int j = 1; j <= DN; j++) begin
      dsh[j] = RW'(den_r[j-1]) << (DN - j);
      if (rem_r[j-1] >= dsh[j]) begin
        rem_nxt[j] = rem_r[j-1] - dsh[j];
        quo_nxt[j] = {quo_r[j-1][DN-2:0], 1'b1};
      end else begin
        rem_nxt[j] = rem_r[j-1];
        quo_nxt[j] = {quo_r[j-1][DN-2:0], 1'b0};
      end
    end
    qs = $signed({1'b0, quo_r[DN]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= RW'(num) << FRAC_BITS;
      den_r[0]  <= den;
      quo_r[0]  <= '0;
      neg_r[0]  <= neg;
      zero_r[0] <= zero;
      for (int j = 1; j <= DN; j++) begin
        if (j < DN) begin
          rem_r[j] <= rem_nxt[j];
          den_r[j] <= den_r[j-1];
        end
        quo_r[j]  <= quo_nxt[j];
        neg_r[j]  <= neg_r[j-1];
        zero_r[j] <= zero_r[j-1];
      end
      if (zero_r[DN]) begin
        out_r <= '0;
      end else if (neg_r[DN]) begin
        out_r <= -qs;
      end else begin
        out_r <= qs;
      end
    end
  end

  assign quo = out_r;

endmodule

### hdl/lav_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_unit
// Vector normalizer: finds the leading one, shifts all three lanes into a
// common range, sums the squares, takes a pipelined square root and divides
// each lane by it.
// ----------------------------------------------------------------------------
module lav_unit #(
  parameter int MAG_W     = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [2:0][MAG_W-1:0]       in_mag,
  input  logic [2:0]                  in_neg,
  output logic [2:0][FRAC_BITS+1:0]   out_vec,
  output logic                        out_zero
);

  localparam int NORM = lav_pkg::NORM_MSB;
  localparam int SW   = NORM + 1;
  localparam int SQ_W = 2 * SW + 2;
  localparam int QW   = SW + 1;
  localparam int SQ_N = lav_pkg::SQRT_STEPS;
  localparam int NG   = (MAG_W + 7) / 8;
  localparam int PADW = NG * 8;
  localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
  localparam int PW   = $clog2(PADW);
  localparam int WDW  = MAG_W + NORM;

  logic [2:0][MAG_W-1:0] m0_r, m1_r, m2_r, m3_r;
  logic [2:0]            n0_r, n1_r, n2_r, n3_r, n4_r, n5_r;
  logic [MAG_W-1:0]      mx1_r;
  logic [GW-1:0]         g2_r;
  logic [7:0]            byte2_r;
  logic                  z2_r, z3_r, z4_r, z5_r;
  logic [PW-1:0]         p3_r;
  logic [2:0][SW-1:0]    s4_r, s5_r;
  logic [2:0][2*SW-1:0]  sq5_r;

  logic [SQ_W:0]         sv_r [0:SQ_N];
  logic [SQ_W:0]         sr_r [0:SQ_N];
  logic [2:0][SW-1:0]    ss_r [0:SQ_N];
  logic [2:0]            sn_r [0:SQ_N];
  logic                  sz_r [0:SQ_N];

  logic [MAG_W-1:0]      mx_nxt;
  logic [PADW-1:0]       mxp;
  logic [GW-1:0]         g_nxt;
  logic [7:0]            byte_nxt;
  logic [2:0]            b_nxt;
  logic [WDW-1:0]        wide [0:2];
  logic [SQ_W:0]         bitc  [1:SQ_N];
  logic [SQ_W:0]         trial [1:SQ_N];
  logic [SQ_W:0]         sv_nxt [1:SQ_N];
  logic [SQ_W:0]         sr_nxt [1:SQ_N];

  always_comb begin
    mx_nxt = m0_r[0];
    if (m0_r[1] > mx_nxt) mx_nxt = m0_r[1];
    if (m0_r[2] > mx_nxt) mx_nxt = m0_r[2];

    mxp   = PADW'(mx1_r);
    g_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      if (|mxp[g*8 +: 8]) g_nxt = GW'(g);
    end
    byte_nxt = mxp[g_nxt*8 +: 8];

    b_nxt = '0;
    for (int b = 0; b < 8; b++) begin
      if (byte2_r[b]) b_nxt = 3'(b);
    end

    for (int i = 0; i < 3; i++) begin
      wide[i] = {m3_r[i], {NORM{1'b0}}} >> p3_r;
    end

    for (int k = 1; k <= SQ_N; k++) begin
      bitc[k]  = (SQ_W+1)'(1) << (2 * (SQ_N - k));
      trial[k] = sr_r[k-1] + bitc[k];
      if (sv_r[k-1] >= trial[k]) begin
        sv_nxt[k] = sv_r[k-1] - trial[k];
        sr_nxt[k] = (sr_r[k-1] >> 1) + bitc[k];
      end else begin
        sv_nxt[k] = sv_r[k-1];
        sr_nxt[k] = sr_r[k-1] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r    <= in_mag;
      n0_r    <= in_neg;
      m1_r    <= m0_r;
      n1_r    <= n0_r;
      mx1_r   <= mx_nxt;
      m2_r    <= m1_r;
      n2_r    <= n1_r;
      g2_r    <= g_nxt;
      byte2_r <= byte_nxt;
      z2_r    <= (mx1_r == '0);
      m3_r    <= m2_r;
      n3_r    <= n2_r;
      z3_r    <= z2_r;
      p3_r    <= PW'({g2_r, b_nxt});
      for (int i = 0; i < 3; i++) begin
        s4_r[i]  <= wide[i][SW-1:0];
        sq5_r[i] <= s4_r[i] * s4_r[i];
      end
      n4_r <= n3_r;
      z4_r <= z3_r;
      s5_r <= s4_r;
      n5_r <= n4_r;
      z5_r <= z4_r;
      sv_r[0] <= (SQ_W+1)'(sq5_r[0]) + (SQ_W+1)'(sq5_r[1]) + (SQ_W+1)'(sq5_r[2]);
      sr_r[0] <= '0;
      ss_r[0] <= s5_r;
      sn_r[0] <= n5_r;
      sz_r[0] <= z5_r;
      for (int k = 1; k <= SQ_N; k++) begin
        sv_r[k] <= sv_nxt[k];
        sr_r[k] <= sr_nxt[k];
        ss_r[k] <= ss_r[k-1];
        sn_r[k] <= sn_r[k-1];
        sz_r[k] <= sz_r[k-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    lav_div_lane #(
      .SW        (SW),
      .QW        (QW),
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk  (clk),
      .en   (en),
      .num  (ss_r[SQ_N][i]),
      .den  (sr_r[SQ_N][QW-1:0]),
      .neg  (sn_r[SQ_N][i]),
      .zero (sz_r[SQ_N]),
      .quo  (out_vec[i])
    );
  end

  lav_delay #(
    .WIDTH (1),
    .DEPTH (FRAC_BITS + 3)
  ) u_zero_dly (
    .clk (clk),
    .en  (en),
    .d   (sz_r[SQ_N]),
    .q   (out_zero)
  );

endmodule

### hdl/lav_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_cross
// Cross product: six product lanes, then the pairwise differences.
// ----------------------------------------------------------------------------
module lav_cross #(
  parameter int IW = 18
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [2:0][IW-1:0]   a,
  input  logic [2:0][IW-1:0]   b,
  output logic [2:0][2*IW:0]   c
);

  logic signed [2*IW-1:0] p_r [0:5];
  logic [2:0][2*IW:0]     c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= $signed(a[1]) * $signed(b[2]);
      p_r[1] <= $signed(a[2]) * $signed(b[1]);
      p_r[2] <= $signed(a[2]) * $signed(b[0]);
      p_r[3] <= $signed(a[0]) * $signed(b[2]);
      p_r[4] <= $signed(a[0]) * $signed(b[1]);
      p_r[5] <= $signed(a[1]) * $signed(b[0]);
      for (int i = 0; i < 3; i++) begin
        c_r[i] <= (2*IW+1)'(p_r[2*i]) - (2*IW+1)'(p_r[2*i+1]);
      end
    end
  end

  assign c = c_r;

endmodule

### hdl/lav_xlate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_xlate
// Translation of one row: three rounded product lanes, merged into the
// negated dot product with the eye point and saturated.
// ----------------------------------------------------------------------------
module lav_xlate #(
  parameter int FRAC_BITS = 16,
  parameter int RWD       = 19
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [2:0][RWD-1:0]                 row,
  input  logic [2:0][lav_pkg::COORD_W-1:0]    eye,
  output logic [lav_pkg::COORD_W-1:0]         col3
);

  localparam int W   = lav_pkg::COORD_W;
  localparam int PRW = RWD + W;
  localparam int TW  = PRW + 1 - FRAC_BITS;
  localparam int TS  = TW + 1;
  localparam int SMW = TS + 2;

  logic [2:0][RWD-1:0] rm_r;
  logic [2:0][W-1:0]   em_r;
  logic [2:0]          ng1_r, ng2_r;
  logic [2:0][PRW-1:0] pr_r;
  logic signed [TS-1:0]  tm_r [0:2];
  logic signed [SMW-1:0] sum_r;
  logic [W-1:0]          col3_r;

  logic signed [RWD:0] rs;
  logic signed [W:0]   es;
  logic [RWD-1:0]      rm_nxt [0:2];
  logic [W-1:0]        em_nxt [0:2];
  logic [PRW:0]        tsum   [0:2];
  logic [TW-1:0]       tmag   [0:2];

  always_comb begin
    rs = '0;
    es = '0;
    for (int i = 0; i < 3; i++) begin
      rs        = (RWD+1)'($signed(row[i]));
      es        = (W+1)'($signed(eye[i]));
      rm_nxt[i] = rs[RWD] ? RWD'(-rs) : RWD'(rs);
      em_nxt[i] = es[W] ? W'(-es) : W'(es);
      tsum[i]   = (PRW+1)'(pr_r[i]) + ((PRW+1)'(1) << (FRAC_BITS - 1));
      tmag[i]   = TW'(tsum[i] >> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rm_r[i]  <= rm_nxt[i];
        em_r[i]  <= em_nxt[i];
        ng1_r[i] <= row[i][RWD-1] ^ eye[i][W-1];
        pr_r[i]  <= PRW'(rm_r[i]) * PRW'(em_r[i]);
        ng2_r[i] <= ng1_r[i];
        tm_r[i]  <= ng2_r[i] ? $signed({1'b0, tmag[i]}) : -$signed({1'b0, tmag[i]});
      end
      sum_r  <= SMW'(tm_r[0]) + SMW'(tm_r[1]) + SMW'(tm_r[2]);
      col3_r <= lav_pkg::sat_coord(64'(sum_r));
    end
  end

  assign col3 = col3_r;

endmodule

### hdl/look_at_view_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Builds the 4x4 look-at view matrix from eye, target and up in signed
// fixed point and emits it one row per result request.
// ----------------------------------------------------------------------------
//  channel   ports                          request
//  input     in_valid / in_ready / in_req   eye, target, up
//  output    out_valid / out_ready / out_req one matrix row
//
//  Each input request yields four rows on consecutive cycles while out_ready
//  stays high; once the pipeline is full, a new request is taken only as the
//  row serializer hands out the last row. Latency to row 0 is set mostly by
//  the square-root and divider chains of the forward/up and side normalizers.
//  Reset clears the valid line and the serializer; no clearing pass.
//  Stalls and serializing rows freeze the pipeline when its last stage is full.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lav_pkg::in_req_t   in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output lav_pkg::out_req_t  out_req
);

  localparam int W     = lav_pkg::COORD_W;
  localparam int OW    = FRAC_BITS + 2;
  localparam int CW    = 2 * OW + 1;
  localparam int RWD   = FRAC_BITS + 3;
  localparam int CL    = lav_pkg::CROSS_LAT;
  localparam int XL    = lav_pkg::XLATE_LAT;
  localparam int ULAT  = lav_pkg::UNIT_PRE + lav_pkg::SQRT_STEPS + FRAC_BITS + 3;
  localparam int DEPTH = 1 + ULAT + CL + ULAT + CL + 1 + XL;
  localparam logic [W-1:0] ONE_Q = W'(1) << FRAC_BITS;

  logic                en;
  logic                load;
  logic                vld_r [0:DEPTH-1];
  lav_pkg::in_req_t    in_r;

  logic [2:0][W-1:0]   eye0, tgt0, up0;
  logic [2:0][W-1:0]   fmag, umag;
  logic [2:0]          fneg, uneg;
  logic signed [W:0]   dfs [0:2];
  logic signed [W:0]   ups [0:2];

  logic [2:0][OW-1:0]  fw_a, upn_a, fw_b, fw_c, fw_d, sd_c, sd_d;
  logic                zf_a, zu_a, deg_b, deg_c, zs_c, deg_d;
  logic [2:0][W-1:0]   eye_a, eye_b, eye_c, eye_d;
  logic [2:0][CW-1:0]  sraw, ur;
  logic [2:0][CW-1:0]  smag;
  logic [2:0]          sneg;
  logic signed [CW:0]  urs [0:2];
  logic [CW:0]         urm [0:2];
  logic [RWD-1:0]      urr [0:2];

  logic [2:0][RWD-1:0] r0_r, r1_r, r2_r;
  logic [2:0][W-1:0]   eye5_r;
  logic                deg5_r;
  logic [W-1:0]        t0, t1, t2;
  logic [2:0][RWD-1:0] r0_x, r1_x, r2_x;
  logic                deg_x;

  logic [3:0][W-1:0]   hold_r [0:2];
  logic                deg_r;
  logic [1:0]          cnt_r;
  logic                out_valid_r;

  assign load     = vld_r[DEPTH-1] && (!out_valid_r || (out_ready && cnt_r == lav_pkg::ROW_LAST));
  assign en       = !vld_r[DEPTH-1] || load;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) in_r <= in_req;
  end

  assign eye0 = {in_r.eye_z, in_r.eye_y, in_r.eye_x};
  assign tgt0 = {in_r.target_z, in_r.target_y, in_r.target_x};
  assign up0  = {in_r.up_z, in_r.up_y, in_r.up_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dfs[i]  = $signed({tgt0[i][W-1], tgt0[i]}) - $signed({eye0[i][W-1], eye0[i]});
      fneg[i] = dfs[i][W];
      fmag[i] = fneg[i] ? W'(-dfs[i]) : W'(dfs[i]);
      ups[i]  = $signed({up0[i][W-1], up0[i]});
      uneg[i] = ups[i][W];
      umag[i] = uneg[i] ? W'(-ups[i]) : W'(ups[i]);
    end
  end

  lav_unit #(.MAG_W(W), .FRAC_BITS(FRAC_BITS)) u_fwd (
    .clk (clk), .en (en), .in_mag (fmag), .in_neg (fneg),
    .out_vec (fw_a), .out_zero (zf_a)
  );

  lav_unit #(.MAG_W(W), .FRAC_BITS(FRAC_BITS)) u_up (
    .clk (clk), .en (en), .in_mag (umag), .in_neg (uneg),
    .out_vec (upn_a), .out_zero (zu_a)
  );

  lav_delay #(.WIDTH(3*W), .DEPTH(ULAT)) u_eye_a (
    .clk (clk), .en (en), .d (eye0), .q (eye_a)
  );

  lav_cross #(.IW(OW)) u_cross_side (
    .clk (clk), .en (en), .a (fw_a), .b (upn_a), .c (sraw)
  );

  lav_delay #(.WIDTH(3*OW + 3*W + 1), .DEPTH(CL)) u_dly_b (
    .clk (clk), .en (en), .d ({fw_a, eye_a, zf_a | zu_a}), .q ({fw_b, eye_b, deg_b})
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sneg[i] = sraw[i][CW-1];
      smag[i] = sneg[i] ? -sraw[i] : sraw[i];
    end
  end

  lav_unit #(.MAG_W(CW), .FRAC_BITS(FRAC_BITS)) u_side (
    .clk (clk), .en (en), .in_mag (smag), .in_neg (sneg),
    .out_vec (sd_c), .out_zero (zs_c)
  );

  lav_delay #(.WIDTH(3*OW + 3*W + 1), .DEPTH(ULAT)) u_dly_c (
    .clk (clk), .en (en), .d ({fw_b, eye_b, deg_b}), .q ({fw_c, eye_c, deg_c})
  );

  lav_cross #(.IW(OW)) u_cross_up (
    .clk (clk), .en (en), .a (sd_c), .b (fw_c), .c (ur)
  );

  lav_delay #(.WIDTH(6*OW + 3*W + 1), .DEPTH(CL)) u_dly_d (
    .clk (clk), .en (en),
    .d ({sd_c, fw_c, eye_c, deg_c | zs_c}),
    .q ({sd_d, fw_d, eye_d, deg_d})
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      urs[i] = (CW+1)'($signed(ur[i]));
      urm[i] = urs[i][CW] ? (CW+1)'(-urs[i]) : (CW+1)'(urs[i]);
      urm[i] = (urm[i] + ((CW+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      urr[i] = urs[i][CW] ? -RWD'(urm[i]) : RWD'(urm[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r0_r[i] <= RWD'($signed(sd_d[i]));
        r1_r[i] <= urr[i];
        r2_r[i] <= -RWD'($signed(fw_d[i]));
      end
      eye5_r <= eye_d;
      deg5_r <= deg_d;
    end
  end

  lav_xlate #(.FRAC_BITS(FRAC_BITS), .RWD(RWD)) u_xlate_side (
    .clk (clk), .en (en), .row (r0_r), .eye (eye5_r), .col3 (t0)
  );

  lav_xlate #(.FRAC_BITS(FRAC_BITS), .RWD(RWD)) u_xlate_up (
    .clk (clk), .en (en), .row (r1_r), .eye (eye5_r), .col3 (t1)
  );

  lav_xlate #(.FRAC_BITS(FRAC_BITS), .RWD(RWD)) u_xlate_fwd (
    .clk (clk), .en (en), .row (r2_r), .eye (eye5_r), .col3 (t2)
  );

  lav_delay #(.WIDTH(9*RWD + 1), .DEPTH(XL)) u_dly_x (
    .clk (clk), .en (en), .d ({r0_r, r1_r, r2_r, deg5_r}), .q ({r0_x, r1_x, r2_x, deg_x})
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= lav_pkg::ROW_SIDE;
    end else if (load) begin
      out_valid_r <= 1'b1;
      cnt_r       <= lav_pkg::ROW_SIDE;
    end else if (out_valid_r && out_ready) begin
      if (cnt_r == lav_pkg::ROW_LAST) begin
        out_valid_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 3; i++) begin
        hold_r[0][i] <= lav_pkg::sat_coord(64'($signed(r0_x[i])));
        hold_r[1][i] <= lav_pkg::sat_coord(64'($signed(r1_x[i])));
        hold_r[2][i] <= lav_pkg::sat_coord(64'($signed(r2_x[i])));
      end
      hold_r[0][3] <= t0;
      hold_r[1][3] <= t1;
      hold_r[2][3] <= t2;
      deg_r        <= deg_x;
    end
  end

  always_comb begin
    out_req.row_index  = cnt_r;
    out_req.degenerate = deg_r;
    out_req.last_row   = (cnt_r == lav_pkg::ROW_LAST);
    case (cnt_r)
      lav_pkg::ROW_SIDE: begin
        out_req.col0 = hold_r[0][0];
        out_req.col1 = hold_r[0][1];
        out_req.col2 = hold_r[0][2];
        out_req.col3 = hold_r[0][3];
      end
      lav_pkg::ROW_UP: begin
        out_req.col0 = hold_r[1][0];
        out_req.col1 = hold_r[1][1];
        out_req.col2 = hold_r[1][2];
        out_req.col3 = hold_r[1][3];
      end
      lav_pkg::ROW_FWD: begin
        out_req.col0 = hold_r[2][0];
        out_req.col1 = hold_r[2][1];
        out_req.col2 = hold_r[2][2];
        out_req.col3 = hold_r[2][3];
      end
      default: begin
        out_req.col0 = '0;
        out_req.col1 = '0;
        out_req.col2 = '0;
        out_req.col3 = ONE_Q;
      end
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  ap_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[DEPTH-1] |-> in_ready)
    else $error("pipeline stalled with an empty last stage");

  ap_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_req.row_index == lav_pkg::ROW_SIDE))
    else $error("matrix did not start at row 0");

  ap_deg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_req.row_index != lav_pkg::ROW_LAST) |=>
    (out_valid && out_req.degenerate == $past(out_req.degenerate)))
    else $error("degenerate flag changed inside a matrix");

  ap_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && cnt_r == lav_pkg::ROW_LAST && !vld_r[DEPTH-1]) |=> !out_valid)
    else $error("result shown with no matrix pending");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives eye/target/up requests into look_at_view_matrix with random gaps on
// both channels and checks every emitted matrix row against a predicted
// matrix held in a scoreboard queue.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FRAC      = 16;
  localparam int N_RANDOM  = 350;
  localparam int LATENCY   = 2 * (41 + FRAC) + 12;
  localparam longint LIMIT = 2000000;

  typedef struct {
    logic        neg;
    logic [63:0] mag;
  } sm_t;

  function automatic logic [63:0] sqrt_u64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic sm_t to_sm(longint x);
    sm_t r;
    r.neg = x < 0;
    r.mag = r.neg ? 64'd0 - x : x;
    return r;
  endfunction

  function automatic logic unit_vec(sm_t v[3], output longint o[3]);
    logic [63:0] m;
    logic [63:0] s[3];
    logic [63:0] sum;
    logic [63:0] q;
    logic [63:0] c;
    int p;
    m = v[0].mag;
    if (v[1].mag > m) m = v[1].mag;
    if (v[2].mag > m) m = v[2].mag;
    if (m == 0) begin
      o[0] = 0; o[1] = 0; o[2] = 0;
      return 1'b1;
    end
    p = 0;
    while (p < 63 && (m >> (p + 1)) != 0) p++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      s[i] = (p > 29) ? (v[i].mag >> (p - 29)) : (v[i].mag << (29 - p));
      sum = sum + s[i] * s[i];
    end
    q = sqrt_u64(sum);
    for (int i = 0; i < 3; i++) begin
      c = (s[i] << FRAC) / q;
      o[i] = v[i].neg ? -longint'(c) : longint'(c);
    end
    return 1'b0;
  endfunction

  function automatic void cross3(longint a[3], longint b[3], output longint o[3]);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint xlate(longint row[3], longint eye[3]);
    longint hi;
    logic [63:0] lo;
    logic [63:0] t;
    logic [63:0] n;
    logic [63:0] fmask;
    sm_t r;
    sm_t e;
    hi = 0;
    lo = 0;
    fmask = (64'd1 << FRAC) - 1;
    for (int i = 0; i < 3; i++) begin
      r = to_sm(row[i]);
      e = to_sm(eye[i]);
      t = (e.mag >> FRAC) * r.mag + (((e.mag & fmask) * r.mag + (64'd1 << (FRAC - 1))) >> FRAC);
      if (r.neg != e.neg) begin
        n = lo + t;
        hi += (n < lo);
        lo = n;
      end else begin
        hi -= (lo < t);
        lo = lo - t;
      end
    end
    if (hi > 0 || (hi == 0 && lo[63])) return sat32(64'sh7fffffffffffffff);
    if (hi < -1 || (hi == -1 && !lo[63])) return sat32(64'sh8000000000000000);
    return sat32(longint'(lo));
  endfunction

  function automatic lav_pkg::out_req_t make_row(logic [1:0] k, longint c[3], longint t,
                                                 logic deg);
    lav_pkg::out_req_t o;
    longint v;
    o.row_index = k;
    v = sat32(c[0]); o.col0 = v[31:0];
    v = sat32(c[1]); o.col1 = v[31:0];
    v = sat32(c[2]); o.col2 = v[31:0];
    o.col3 = t[31:0];
    o.degenerate = deg;
    o.last_row = (k == lav_pkg::ROW_LAST);
    return o;
  endfunction

  class matrix_board;
    lav_pkg::out_req_t rows_due[$];
    int errors;
    int rows_seen;

    function void note_request(lav_pkg::in_req_t r);
      longint eye[3], tgt[3], up[3], fw[3], upn[3], sraw[3], sd[3], ur[3];
      longint uu[3], nf[3], zr[3], mg;
      sm_t v[3];
      logic deg;
      eye = '{r.eye_x, r.eye_y, r.eye_z};
      tgt = '{r.target_x, r.target_y, r.target_z};
      up  = '{r.up_x, r.up_y, r.up_z};
      for (int i = 0; i < 3; i++) begin
        v[i].neg = tgt[i] < eye[i];
        v[i].mag = v[i].neg ? eye[i] - tgt[i] : tgt[i] - eye[i];
      end
      deg = unit_vec(v, fw);
      for (int i = 0; i < 3; i++) v[i] = to_sm(up[i]);
      deg = unit_vec(v, upn) | deg;
      cross3(fw, upn, sraw);
      for (int i = 0; i < 3; i++) v[i] = to_sm(sraw[i]);
      deg = unit_vec(v, sd) | deg;
      cross3(sd, fw, ur);
      for (int i = 0; i < 3; i++) begin
        v[i] = to_sm(ur[i]);
        mg = longint'((v[i].mag + (64'd1 << (FRAC - 1))) >> FRAC);
        uu[i] = v[i].neg ? -mg : mg;
        nf[i] = -fw[i];
        zr[i] = 0;
      end
      rows_due.push_back(make_row(lav_pkg::ROW_SIDE, sd, xlate(sd, eye), deg));
      rows_due.push_back(make_row(lav_pkg::ROW_UP, uu, xlate(uu, eye), deg));
      rows_due.push_back(make_row(lav_pkg::ROW_FWD, nf, xlate(nf, eye), deg));
      rows_due.push_back(make_row(lav_pkg::ROW_LAST, zr, 64'sd65536, deg));
    endfunction

    function void check_row(lav_pkg::out_req_t got);
      lav_pkg::out_req_t want;
      rows_seen++;
      if (rows_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected row %p", got);
        return;
      end
      want = rows_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("row mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  lav_pkg::in_req_t in_req = '0;
  logic out_valid;
  logic out_ready = 0;
  lav_pkg::out_req_t out_req;
  matrix_board board = new();
  longint cycles = 0;
  int n_deg = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  look_at_view_matrix #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_req(in_req), .out_valid(out_valid), .out_ready(out_ready), .out_req(out_req)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_valid && in_ready) board.note_request(in_req);
    if (rst_n && out_valid && out_ready) begin
      if (out_req.degenerate && out_req.last_row) n_deg++;
      board.check_row(out_req);
    end
    if (cycles > LIMIT) begin
      $display("timeout");
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(0, 3)) @(negedge clk) out_ready <= 1'b0;
      end
    end
  end

  task automatic send_request(lav_pkg::in_req_t r);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic lav_pkg::in_req_t rnd_view();
    lav_pkg::in_req_t r;
    r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
         $urandom(), $urandom(), $urandom(), $urandom()};
    if ($urandom_range(0, 3) != 0) begin
      r.eye_x = rnd_coord(); r.eye_y = rnd_coord(); r.eye_z = rnd_coord();
      r.target_x = rnd_coord(); r.target_y = rnd_coord(); r.target_z = rnd_coord();
      r.up_x = rnd_coord(); r.up_y = rnd_coord(); r.up_z = rnd_coord();
    end
    case ($urandom_range(0, 11))
      0: {r.target_x, r.target_y, r.target_z} = {r.eye_x, r.eye_y, r.eye_z};
      1: {r.up_x, r.up_y, r.up_z} = '0;
      2: {r.up_x, r.up_y, r.up_z} = {r.target_x - r.eye_x, r.target_y - r.eye_y,
                                      r.target_z - r.eye_z};
      default: ;
    endcase
    return r;
  endfunction

  lav_pkg::in_req_t d;
  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    // directed: unit cases, zero forward, zero up, parallel up, extremes
    d = '0; d.target_z = -32'sd65536; d.up_y = 32'sd65536; send_request(d);
    d = '0; d.eye_x = 32'sd655360; d.up_y = 32'sd65536; send_request(d);
    d = '0; d.up_y = 32'sd65536; send_request(d);
    d = '0; d.target_x = 32'sd65536; send_request(d);
    d = '0; d.target_y = 32'sd65536; d.up_y = 32'sd131072; send_request(d);
    d = '0; d.target_y = 32'sd65536; d.up_y = -32'sd1; send_request(d);
    d = '1; send_request(d);
    d = {9{32'h7fffffff}}; d.target_x = 32'h80000000; send_request(d);
    d = {9{32'h80000000}}; d.target_x = 32'h7fffffff; d.up_z = 32'h7fffffff;
    send_request(d);
    d = '0; d.eye_x = 32'h7fffffff; d.eye_y = 32'h80000000; d.eye_z = 32'h7fffffff;
    d.target_x = 32'h80000000; d.target_y = 32'h7fffffff; d.target_z = 32'h80000000;
    d.up_x = 32'h80000000; d.up_y = 32'h7fffffff; d.up_z = 32'sd1;
    send_request(d);
    d = '0; d.eye_z = 32'h7fffffff; d.target_x = 32'sd1; d.up_y = 32'sd1; send_request(d);
    d = '0; d.eye_x = 32'sd3; d.eye_y = -32'sd5; d.target_x = 32'sd1;
    d.target_z = 32'sd1; d.up_x = 32'sd1; d.up_y = 32'sd1; send_request(d);
    for (int i = 0; i < N_RANDOM; i++) send_request(rnd_view());
    in_valid <= 1'b0;
    while (board.rows_due.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    $display("covered %0d matrix rows, %0d degenerate matrices", board.rows_seen, n_deg);
    if (board.errors == 0 && board.rows_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
